// File: src/tbuuid_pkg.sv
// ----------------------------------------------------------------------------
// Time-based UUID generator package
// Shared widths, constants and item types for the UUID generator.
// ----------------------------------------------------------------------------
package tbuuid_pkg;

    localparam int SEC_W   = 36;
    localparam int USEC_W  = 20;
    localparam int RCLK_W  = 14;
    localparam int NODE_W  = 48;
    localparam int TICK_W  = 60;
    localparam int SEQ_W   = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 48;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [SEQ_W-1:0]   TICK_LIMIT      = 4'd10;
    localparam logic [USEC_W-1:0]  MICROS_PER_SEC  = 20'd1000000;
    localparam logic [TICK_W-1:0]  EPOCH_OFFSET    = 60'd122192928000000000;
    localparam logic [NODE_W-1:0]  MAC_RESET       = 48'h010000000000;
    localparam int                 NODE_MCAST_BIT  = 40;
    localparam int                 NODE_LOCAL_BIT  = 41;
    localparam logic [3:0]         UUID_VERSION    = 4'h1;
    localparam logic [1:0]         UUID_VARIANT    = 2'b10;

    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_RANDOM_NODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAC_ADDRESS       = 8'd1;

    typedef struct packed {
        logic              force_random_node;
        logic [NODE_W-1:0] mac_address;
    } t_cfg;

    typedef struct packed {
        logic [SEC_W-1:0]  seconds;
        logic [USEC_W-1:0] micros;
        logic [RCLK_W-1:0] random_clock;
        logic [NODE_W-1:0] random_node;
        logic [TICK_W-1:0] tick_base;
    } t_item;

endpackage

// File: src/tbuuid_front.sv
// ----------------------------------------------------------------------------
// UUID generator front end
// Accepts an item and forms its tick count since 1582, before the
// tick sequence is added, then hands it to the queue.
// ----------------------------------------------------------------------------
module tbuuid_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tbuuid_pkg::SEC_W-1:0]  i_time_seconds,
    input  logic [tbuuid_pkg::USEC_W-1:0] i_time_micros,
    input  logic [tbuuid_pkg::RCLK_W-1:0] i_random_clock,
    input  logic [tbuuid_pkg::NODE_W-1:0] i_random_node,
    output logic                          o_push,
    output tbuuid_pkg::t_item             o_item,
    input  logic                          i_full
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam int HALF   = tbuuid_pkg::SEC_W / 2;
    localparam int PROD_W = HALF + tbuuid_pkg::USEC_W;
    localparam int SUM_W  = tbuuid_pkg::SEC_W + tbuuid_pkg::USEC_W;

    logic [1:0]                    r_state, n_state;
    logic [tbuuid_pkg::SEC_W-1:0]  r_sec;
    logic [tbuuid_pkg::USEC_W-1:0] r_usec;
    logic [tbuuid_pkg::RCLK_W-1:0] r_rclk;
    logic [tbuuid_pkg::NODE_W-1:0] r_rnode;
    logic [PROD_W-1:0]             r_p_hi, r_p_lo;
    logic [SUM_W-1:0]              r_sum;
    logic [tbuuid_pkg::TICK_W-1:0] w_sum_ext;
    logic [tbuuid_pkg::TICK_W-1:0] w_tick_base;

    assign o_stall = (r_state != ST_IDLE);

    assign w_sum_ext   = tbuuid_pkg::TICK_W'(r_sum);
    assign w_tick_base = (w_sum_ext << 3) + (w_sum_ext << 1) + tbuuid_pkg::EPOCH_OFFSET;

    assign o_push = (r_state == ST_FIN);
    assign o_item = '{seconds:      r_sec,
                      micros:       r_usec,
                      random_clock: r_rclk,
                      random_node:  r_rnode,
                      tick_base:    w_tick_base};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!i_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_sec   <= i_time_seconds;
            r_usec  <= i_time_micros;
            r_rclk  <= i_random_clock;
            r_rnode <= i_random_node;
        end
        if (r_state == ST_MUL) begin
            r_p_hi <= PROD_W'(r_sec[tbuuid_pkg::SEC_W-1:HALF]) *
                      PROD_W'(tbuuid_pkg::MICROS_PER_SEC);
            r_p_lo <= PROD_W'(r_sec[HALF-1:0]) * PROD_W'(tbuuid_pkg::MICROS_PER_SEC);
        end
        if (r_state == ST_SUM) begin
            r_sum <= (SUM_W'(r_p_hi) << HALF) + SUM_W'(r_p_lo) + SUM_W'(r_usec);
        end
    end

endmodule

// File: src/tbuuid_queue.sv
// ----------------------------------------------------------------------------
// UUID generator queue
// Short first-in first-out buffer of items between front and back end.
// ----------------------------------------------------------------------------
module tbuuid_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tbuuid_pkg::t_item i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output tbuuid_pkg::t_item o_item
);

    localparam int DEPTH = tbuuid_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    tbuuid_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              w_wr, w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: src/tbuuid_back.sv
// ----------------------------------------------------------------------------
// UUID generator back end
// Keeps the time, tick and clock sequence state, builds the UUID and
// holds it in the output register until it is taken.
// ----------------------------------------------------------------------------
module tbuuid_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tbuuid_pkg::t_cfg              i_cfg,
    input  logic                          i_q_valid,
    input  tbuuid_pkg::t_item             i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_status,
    output logic [63:0]                   o_uuid_upper,
    output logic [63:0]                   o_uuid_lower
);

    logic [tbuuid_pkg::SEC_W-1:0]  r_prev_sec;
    logic [tbuuid_pkg::USEC_W-1:0] r_prev_usec;
    logic [tbuuid_pkg::SEQ_W-1:0]  r_tick_seq;
    logic [tbuuid_pkg::RCLK_W-1:0] r_clk_seq;
    logic                          r_out_valid;
    logic                          r_status;
    logic [63:0]                   r_upper, r_lower;

    logic                          w_same, w_back, w_exhausted, w_rand_node;
    logic [tbuuid_pkg::SEQ_W-1:0]  w_tick;
    logic [tbuuid_pkg::TICK_W-1:0] w_t;
    logic [tbuuid_pkg::RCLK_W-1:0] w_clk_seq;
    logic [tbuuid_pkg::NODE_W-1:0] w_node;

    assign o_pop        = i_q_valid && (!r_out_valid || !i_stall);
    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_uuid_upper = r_upper;
    assign o_uuid_lower = r_lower;

    always_comb begin
        w_same = (i_item.seconds == r_prev_sec) && (i_item.micros == r_prev_usec);
        w_back = (i_item.seconds < r_prev_sec) ||
                 ((i_item.seconds == r_prev_sec) && (i_item.micros < r_prev_usec));
        w_exhausted = w_same && (r_tick_seq >= tbuuid_pkg::TICK_LIMIT);
        w_tick = w_same ? r_tick_seq + 1'b1 : '0;
        w_t    = i_item.tick_base + tbuuid_pkg::TICK_W'(w_tick);
        w_clk_seq = ((r_clk_seq == '0) || w_back) ? i_item.random_clock
                                                  : r_clk_seq + 1'b1;
        w_rand_node = i_cfg.force_random_node ||
                      i_cfg.mac_address[tbuuid_pkg::NODE_MCAST_BIT];
        w_node = i_cfg.mac_address;
        if (w_rand_node) begin
            w_node = i_item.random_node;
            w_node[tbuuid_pkg::NODE_MCAST_BIT] = 1'b1;
            w_node[tbuuid_pkg::NODE_LOCAL_BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev_sec  <= '0;
            r_prev_usec <= '0;
            r_tick_seq  <= '0;
            r_clk_seq   <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && !w_exhausted) begin
                r_prev_sec  <= i_item.seconds;
                r_prev_usec <= i_item.micros;
                r_tick_seq  <= w_tick;
                r_clk_seq   <= w_clk_seq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (w_exhausted) begin
                r_status <= 1'b1;
                r_upper  <= '0;
                r_lower  <= '0;
            end else begin
                r_status <= 1'b0;
                r_upper  <= {w_t[31:0], w_t[47:32], tbuuid_pkg::UUID_VERSION, w_t[59:48]};
                r_lower  <= {tbuuid_pkg::UUID_VARIANT, w_clk_seq[13:8], w_clk_seq[7:0],
                             w_node};
            end
        end
    end

endmodule

// File: src/time_based_uuid_generator_unit.sv
// ----------------------------------------------------------------------------
// Time-based UUID generator
// Produces version 1 UUIDs from the current time, a clock sequence and
// a node that is either the MAC address or a random multicast node.
// ----------------------------------------------------------------------------
// An item passes through the front end's multiply, sum and scale states, the
// queue and the output register; the input takes no new item until the front
// end is done with the last. A two-entry queue sits before the back end,
// which retires one item per cycle into the output register when not stalled.
// Reset clears the time, tick and clock sequence state and the control registers, not the data registers.
// ----------------------------------------------------------------------------
module time_based_uuid_generator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [tbuuid_pkg::SEC_W-1:0]      i_time_seconds,
    input  logic [tbuuid_pkg::USEC_W-1:0]     i_time_micros,
    input  logic [tbuuid_pkg::RCLK_W-1:0]     i_random_clock,
    input  logic [tbuuid_pkg::NODE_W-1:0]     i_random_node,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_status,
    output logic [63:0]                       o_uuid_upper,
    output logic [63:0]                       o_uuid_lower,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tbuuid_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tbuuid_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tbuuid_pkg::t_cfg  r_cfg;
    tbuuid_pkg::t_item w_push_item, w_pop_item;
    logic              w_push, w_full, w_pop, w_q_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.force_random_node <= 1'b0;
            r_cfg.mac_address       <= tbuuid_pkg::MAC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tbuuid_pkg::CFG_FORCE_RANDOM_NODE: begin
                    r_cfg.force_random_node <= i_cfg_data[0];
                end
                tbuuid_pkg::CFG_MAC_ADDRESS: begin
                    r_cfg.mac_address <= i_cfg_data[tbuuid_pkg::NODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    tbuuid_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_time_seconds (i_time_seconds),
        .i_time_micros  (i_time_micros),
        .i_random_clock (i_random_clock),
        .i_random_node  (i_random_node),
        .o_push         (w_push),
        .o_item         (w_push_item),
        .i_full         (w_full)
    );

    tbuuid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_pop_item)
    );

    tbuuid_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (w_q_valid),
        .i_item       (w_pop_item),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_uuid_upper (o_uuid_upper),
        .o_uuid_lower (o_uuid_lower)
    );

endmodule
